/* rtl/uitoa_pkg.sv */
// Shared types, constants and helpers for the unsigned-to-ASCII digit converter.
package uitoa_pkg;

    // Field widths of the external ports
    localparam int VAL_W    = 32;
    localparam int RADIX_W  = 6;
    localparam int CHAR_W   = 7;

    // Default width of the number that is converted
    localparam int VALUE_WIDTH_DEF = 32;

    // Radix limits
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    // ASCII mapping constants
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;
    localparam logic [CHAR_W-1:0] CHAR_MAX   = 7'd90;
    localparam logic [CHAR_W-1:0] LETTER_GAP = 7'd7;

    // Depth of the job queue between front and back
    localparam int QDEPTH = 2;

    // One conversion job as it travels from front to back
    typedef struct packed {
        logic [VAL_W-1:0]   num;
        logic [RADIX_W-1:0] radix;
    } t_job;

    // Digit value to ASCII: '0'..'9', then 'A' onward
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        c = CHAR_ZERO + {1'b0, d};
        if (c > CHAR_NINE) begin
            c = c + LETTER_GAP;
        end
        return c;
    endfunction

endpackage

/* rtl/uitoa_front.sv */
// Front end: accepts transactions, masks the value and saturates the radix.
module uitoa_front
    import uitoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [VAL_W-1:0]   i_value,
    input  logic [RADIX_W-1:0] i_radix,
    output logic               o_q_push,
    input  logic               i_q_full,
    output t_job               o_q_job
);

    localparam int NUM_W = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;
    localparam logic [VAL_W-1:0] NUM_MASK = {VAL_W{1'b1}} >> (VAL_W - NUM_W);

    logic r_valid, n_valid;
    t_job r_job, n_job;
    t_job job_in;
    logic accept;

    // Mask the incoming value and saturate its radix
    always_comb begin
        job_in.num = i_value & NUM_MASK;
        if (i_radix < RADIX_MIN) begin
            job_in.radix = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            job_in.radix = RADIX_MAX;
        end else begin
            job_in.radix = i_radix;
        end
    end

    // Holding stage: refills in the cycle it drains into the queue
    assign full     = r_valid && i_q_full;
    assign accept   = push && !full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_job  = r_job;

    always_comb begin
        n_valid = r_valid;
        n_job   = r_job;
        if (accept) begin
            n_valid = 1'b1;
            n_job   = job_in;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

endmodule

/* rtl/uitoa_queue.sv */
// Short job queue that decouples the front end from the divider back end.
module uitoa_queue
    import uitoa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_job             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

/* rtl/uitoa_back.sv */
// Back end: bit-serial divider, digit stack and result output register.
module uitoa_back
    import uitoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  t_job              i_q_job,
    output logic              o_q_pop,
    output logic              empty,
    input  logic              pop,
    output logic [CHAR_W-1:0] o_digit_char,
    output logic              o_last
);

    localparam int NUM_W = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;
    localparam int BIT_W = $clog2(NUM_W);
    localparam int IDX_W = $clog2(NUM_W);
    localparam int CNT_W = $clog2(NUM_W + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]         r_state;
    logic [NUM_W-1:0]   r_num;
    logic [RADIX_W-1:0] r_radix;
    logic [RADIX_W-1:0] r_rem;
    logic [BIT_W-1:0]   r_bit;
    logic [CNT_W-1:0]   r_dcnt;
    logic [IDX_W-1:0]   r_rd;
    logic [RADIX_W-1:0] r_stack [NUM_W];
    logic               r_ov;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    logic [RADIX_W:0]   partial;
    logic               ge;
    logic [RADIX_W:0]   diff;
    logic [RADIX_W-1:0] rem_nx;
    logic [NUM_W-1:0]   q_nx;
    logic               div_done;
    logic               ld;

    // One restoring-division step per cycle
    assign partial  = {r_rem, r_num[NUM_W-1]};
    assign ge       = (partial >= {1'b0, r_radix});
    assign diff     = partial - {1'b0, r_radix};
    assign rem_nx   = ge ? diff[RADIX_W-1:0] : partial[RADIX_W-1:0];
    assign q_nx     = {r_num[NUM_W-2:0], ge};
    assign div_done = (r_state == S_DIV) && (r_bit == BIT_W'(NUM_W - 1));

    // Handshakes
    assign o_q_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign ld           = (r_state == S_EMIT) && (!r_ov || pop);
    assign empty        = !r_ov;
    assign o_digit_char = r_char;
    assign o_last       = r_last;

    // Sequencer: take a job, divide digit by digit, then unload the stack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done && (q_nx == '0)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (ld && (r_rd == '0)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (ld) begin
                r_ov <= 1'b1;
            end else if (pop && r_ov) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_num   <= i_q_job.num[NUM_W-1:0];
            r_radix <= i_q_job.radix;
            r_rem   <= '0;
            r_bit   <= '0;
            r_dcnt  <= '0;
        end else if (r_state == S_DIV) begin
            if (div_done) begin
                r_stack[r_dcnt[IDX_W-1:0]] <= rem_nx;
                r_dcnt <= r_dcnt + 1'b1;
                r_rd   <= r_dcnt[IDX_W-1:0];
                r_num  <= q_nx;
                r_rem  <= '0;
                r_bit  <= '0;
            end else begin
                r_num <= q_nx;
                r_rem <= rem_nx;
                r_bit <= r_bit + 1'b1;
            end
        end else if (ld) begin
            r_rd <= r_rd - 1'b1;
        end
    end

    // Output register, most significant digit first
    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_char <= digit_to_ascii(r_stack[r_rd]);
            r_last <= (r_rd == '0);
        end
    end

    // Checks
    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_radix))
        else $error("partial remainder not below radix");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_dcnt <= CNT_W'(NUM_W)))
        else $error("digit count beyond value width");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> ((r_char >= CHAR_ZERO) && (r_char <= CHAR_MAX)))
        else $error("result character out of range");

    a_last_ends_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld && (r_rd == '0)) |=> ((r_state == S_IDLE) && r_last))
        else $error("last character did not end the job");

endmodule

/* rtl/unsigned_to_ascii_digits.sv */
// Top level of the unsigned-to-ASCII digit converter.
//
//  Channel   Handshake         Payload
//  input     push / full       i_value[31:0], i_radix[5:0]
//  result    empty / pop       o_digit_char[6:0], o_last
//
// One bit-serial divider sets the rate: after the job is picked up, each digit takes a full
// pass over the value's bits (value width at most 32), and then the characters are unloaded.
// Reset is synchronous, active low, and clears the valid flags, queue pointers and count, and sequencer state.
// A two-entry job queue and a holding stage let new items in while a job divides.
// A stalled result holds the unload, and the next job does not start dividing until this unload ends.
module unsigned_to_ascii_digits
    import uitoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [VAL_W-1:0]   i_value,
    input  logic [RADIX_W-1:0] i_radix,
    output logic               empty,
    input  logic               pop,
    output logic [CHAR_W-1:0]  o_digit_char,
    output logic               o_last
);

    logic q_push, q_full, q_pop, q_empty;
    t_job q_in, q_out;

    uitoa_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_value  (i_value),
        .i_radix  (i_radix),
        .o_q_push (q_push),
        .i_q_full (q_full),
        .o_q_job  (q_in)
    );

    uitoa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_out)
    );

    uitoa_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_job      (q_out),
        .o_q_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule
